### rtl/ctb_pkg.sv
// Shared types and codes for the cell tracker with best-signal serving cell selection.
package ctb_pkg;

	typedef enum logic [2:0] {
		OP_START      = 3'd0,
		OP_STOP       = 3'd1,
		OP_TICK_BEGIN = 3'd2,
		OP_ACK        = 3'd3,
		OP_TICK_END   = 3'd4
	} op_t;

	typedef enum logic [1:0] {
		MODE_IDLE      = 2'd0,
		MODE_SEARCHING = 2'd1,
		MODE_CONNECTED = 2'd2,
		MODE_LOST      = 2'd3
	} link_mode_t;

	localparam logic REG_CELL_TIMEOUT   = 1'b0;
	localparam logic REG_BEACON_INTERVAL = 1'b1;

	localparam logic [3:0]  VALID_CELLS_MAX = 4'd15;
	localparam logic [15:0] FIRST_ID        = 16'd1;
	localparam logic [31:0] TIMEOUT_RESET   = 32'd2000;
	localparam logic [31:0] INTERVAL_RESET  = 32'd1000;

	// One table slot as held in the slot memory.
	typedef struct packed {
		logic [63:0]        key;
		logic signed [7:0]  level;
		logic [31:0]        seen;
		logic [15:0]        id;
	} slot_entry_t;

	// Scan control from the sequencer to the selector.
	typedef struct packed {
		logic init;
		logic act;
		logic key_mode;
		logic slot_valid;
	} sel_ctl_t;

	// Running result of a scan.
	typedef struct packed {
		logic               found;
		logic signed [7:0]  level;
		logic [15:0]        id;
	} sel_res_t;

endpackage

### rtl/ctb_select.sv
// Scan selector: first key match or strongest valid slot over one memory beat per cycle.
module ctb_select import ctb_pkg::*; #(
	parameter int AW = 3
) (
	input  logic              clk,
	input  logic              arst_n,
	input  sel_ctl_t          ctl,
	input  logic [AW-1:0]     idx,
	input  slot_entry_t       entry,
	input  logic [63:0]       key,
	output sel_res_t          res,
	output logic [AW-1:0]     best_idx
);

	logic              found_q;
	logic signed [7:0] level_q;
	logic [15:0]       id_q;
	logic [AW-1:0]     idx_q;
	logic              take;

	always_comb begin
		take = 1'b0;
		if (ctl.act && ctl.slot_valid) begin
			if (ctl.key_mode) begin
				// first hit wins
				take = !found_q && (entry.key == key);
			end else begin
				// strictly stronger only, so ties stay with the lower slot
				take = !found_q || (entry.level > level_q);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
		end else if (ctl.init) begin
			found_q <= 1'b0;
		end else if (take) begin
			found_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!ctl.init && take) begin
			level_q <= entry.level;
			id_q    <= entry.id;
			idx_q   <= idx;
		end
	end

	assign res.found = found_q;
	assign res.level = level_q;
	assign res.id    = id_q;
	assign best_idx  = idx_q;

endmodule

### rtl/cell_tracker_best_signal_top.sv
// Top level of the cell tracker with best-signal serving cell selection.
// The tracker keeps NUM_CELLS radio cells in a slot memory with one read port and
// one write port; valid bits sit in flip-flops. Every accepted beat gives exactly one
// result beat. Start, stop, tick end, unknown ops and any op while idle go straight
// to the result. Tick begin walks the memory once to expire stale cells, and once
// more when the serving cell expired and a new one is picked. A heartbeat ack
// walks the memory for the key, writes the slot and walks it again for the
// strongest cell, or stops after the first walk when the key is new and the table
// is full. The memory gives one slot read per cycle. A result that still waits
// in the output register holds the next result back. A new input beat is
// taken while the last result still waits in the output register.
module cell_tracker_best_signal_top import ctb_pkg::*; #(
	parameter int NUM_CELLS = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic               cfg_index,
	input  logic [31:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [2:0]         op,
	input  logic [31:0]        now_time_ms,
	input  logic [63:0]        cell_key,
	input  logic signed [7:0]  signal_dbm,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [1:0]         link_state,
	output logic               serving_present,
	output logic [15:0]        serving_id,
	output logic signed [7:0]  serving_level,
	output logic [3:0]         valid_cells,
	output logic               beacon_due,
	output logic               ack_taken
);

	localparam int AW  = (NUM_CELLS > 1) ? $clog2(NUM_CELLS) : 1;
	localparam int CW  = $clog2(NUM_CELLS + 1);
	localparam logic [CW-1:0] LAST_CNT = CW'(NUM_CELLS);

	typedef enum logic [5:0] {
		S_IDLE  = 6'b000001,
		S_EXP   = 6'b000010,
		S_KEY   = 6'b000100,
		S_WRITE = 6'b001000,
		S_PICK  = 6'b010000,
		S_DONE  = 6'b100000
	} state_t;

	state_t             state_q;
	link_mode_t         mode_q;
	logic [31:0]        timeout_q;
	logic [31:0]        interval_q;
	logic [NUM_CELLS-1:0] valid_q;
	logic [CW-1:0]      total_q;
	logic [15:0]        next_id_q;
	logic [31:0]        last_beacon_q;
	logic               serving_has_q;
	logic [AW-1:0]      serving_slot_q;
	logic [15:0]        serving_id_q;
	logic signed [7:0]  serving_level_q;
	logic               lost_q;
	logic               due_q;
	logic               taken_q;
	logic [CW-1:0]      cnt_q;

	logic [2:0]         op_q;
	logic [31:0]        now_q;
	logic [63:0]        key_q;
	logic signed [7:0]  level_q;

	logic               act_s1;
	logic [AW-1:0]      idx_s1;
	slot_entry_t        rd_s1;

	slot_entry_t        mem [NUM_CELLS];

	logic               accept;
	logic               scanning;
	logic               rd_en;
	logic               scan_done;
	logic               init_scan;
	logic               free_any;
	logic [AW-1:0]      free_idx;
	logic               mem_we;
	logic [AW-1:0]      mem_wa;
	slot_entry_t        mem_wd;
	logic [31:0]        age;
	logic [31:0]        since_beacon;
	logic               expire;
	logic               out_load;
	logic [CW+3:0]      total_ext;
	sel_ctl_t           sel_ctl;
	sel_res_t           sel_res;
	logic [AW-1:0]      sel_idx;
	logic               out_valid_q;
	logic [1:0]         link_state_q;
	logic               serving_present_q;
	logic [15:0]        serving_id_out_q;
	logic signed [7:0]  serving_level_out_q;
	logic [3:0]         valid_cells_q;
	logic               beacon_due_q;
	logic               ack_taken_q;

	assign in_ready  = (state_q == S_IDLE);
	assign accept    = in_valid && in_ready;
	assign scanning  = (state_q == S_EXP) || (state_q == S_KEY) || (state_q == S_PICK);
	assign rd_en     = scanning && (cnt_q != LAST_CNT);
	assign scan_done = scanning && (cnt_q == LAST_CNT) && !act_s1;
	assign out_load  = (state_q == S_DONE) && (!out_valid_q || out_ready);

	// Start a fresh search in the selector on the edge that enters a scan.
	assign init_scan = (accept && (op == OP_ACK) && (mode_q != MODE_IDLE))
		|| ((state_q == S_EXP) && scan_done && (lost_q || (act_s1 && expire &&
			serving_has_q && (serving_slot_q == idx_s1))))
		|| ((state_q == S_WRITE) && (sel_res.found || free_any));

	// Lowest free slot.
	always_comb begin
		free_idx = '0;
		for (int i = NUM_CELLS - 1; i >= 0; i--) begin
			if (!valid_q[i]) begin
				free_idx = AW'(i);
			end
		end
	end
	assign free_any = ~&valid_q;

	assign age          = now_q - rd_s1.seen;
	assign since_beacon = now_q - last_beacon_q;
	assign expire       = valid_q[idx_s1] && (age > timeout_q);

	always_comb begin
		mem_we       = (state_q == S_WRITE) && (sel_res.found || free_any);
		mem_wa       = sel_res.found ? sel_idx : free_idx;
		mem_wd.key   = key_q;
		mem_wd.level = level_q;
		mem_wd.seen  = now_q;
		mem_wd.id    = sel_res.found ? sel_res.id : next_id_q;
	end

	assign sel_ctl.init       = init_scan;
	assign sel_ctl.act        = act_s1;
	assign sel_ctl.key_mode   = (state_q == S_KEY);
	assign sel_ctl.slot_valid = valid_q[idx_s1];

	ctb_select #(
		.AW(AW)
	) u_select (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (sel_ctl),
		.idx      (idx_s1),
		.entry    (rd_s1),
		.key      (key_q),
		.res      (sel_res),
		.best_idx (sel_idx)
	);

	// Slot memory: one write, one registered read.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		if (rd_en) begin
			rd_s1 <= mem[cnt_q[AW-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_s1 <= 1'b0;
			idx_s1 <= '0;
		end else begin
			act_s1 <= rd_en;
			idx_s1 <= cnt_q[AW-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q    <= op;
			now_q   <= now_time_ms;
			key_q   <= cell_key;
			level_q <= signal_dbm;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q  <= TIMEOUT_RESET;
			interval_q <= INTERVAL_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_CELL_TIMEOUT:    timeout_q  <= cfg_data;
				REG_BEACON_INTERVAL: interval_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= S_IDLE;
			mode_q          <= MODE_IDLE;
			valid_q         <= '0;
			total_q         <= '0;
			next_id_q       <= FIRST_ID;
			last_beacon_q   <= '0;
			serving_has_q   <= 1'b0;
			serving_slot_q  <= '0;
			serving_id_q    <= '0;
			serving_level_q <= '0;
			lost_q          <= 1'b0;
			due_q           <= 1'b0;
			taken_q         <= 1'b0;
			cnt_q           <= '0;
		end else begin
			if (rd_en) begin
				cnt_q <= cnt_q + 1'b1;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						due_q   <= 1'b0;
						taken_q <= 1'b0;
						lost_q  <= 1'b0;
						cnt_q   <= '0;
						state_q <= S_DONE;
						case (op)
							OP_START: begin
								valid_q       <= '0;
								total_q       <= '0;
								serving_has_q <= 1'b0;
								last_beacon_q <= '0;
								mode_q        <= MODE_SEARCHING;
							end
							OP_STOP: begin
								valid_q       <= '0;
								total_q       <= '0;
								serving_has_q <= 1'b0;
								mode_q        <= MODE_IDLE;
							end
							OP_TICK_BEGIN: begin
								if (mode_q != MODE_IDLE) begin
									state_q <= S_EXP;
								end
							end
							OP_ACK: begin
								if (mode_q != MODE_IDLE) begin
									state_q <= S_KEY;
								end
							end
							OP_TICK_END: begin
								case (mode_q)
									MODE_SEARCHING: begin
										if (serving_has_q) mode_q <= MODE_CONNECTED;
									end
									MODE_CONNECTED: begin
										if (!serving_has_q) mode_q <= MODE_LOST;
									end
									MODE_LOST: begin
										if (serving_has_q) mode_q <= MODE_CONNECTED;
									end
									default: begin
									end
								endcase
							end
							default: begin
							end
						endcase
					end
				end
				S_EXP: begin
					if (act_s1 && expire) begin
						valid_q[idx_s1] <= 1'b0;
						if (total_q != '0) begin
							total_q <= total_q - 1'b1;
						end
						if (serving_has_q && (serving_slot_q == idx_s1)) begin
							lost_q <= 1'b1;
						end
					end
					if (scan_done) begin
						if ((last_beacon_q == '0) || (since_beacon >= interval_q)) begin
							due_q         <= 1'b1;
							last_beacon_q <= now_q;
						end
						cnt_q   <= '0;
						state_q <= lost_q ? S_PICK : S_DONE;
					end
				end
				S_KEY: begin
					if (scan_done) begin
						state_q <= S_WRITE;
					end
				end
				S_WRITE: begin
					cnt_q <= '0;
					if (sel_res.found) begin
						taken_q <= 1'b1;
						state_q <= S_PICK;
					end else if (free_any) begin
						valid_q[free_idx] <= 1'b1;
						next_id_q         <= next_id_q + 1'b1;
						total_q           <= total_q + 1'b1;
						taken_q           <= 1'b1;
						state_q           <= S_PICK;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_PICK: begin
					if (scan_done) begin
						serving_has_q   <= sel_res.found;
						serving_slot_q  <= sel_idx;
						serving_id_q    <= sel_res.id;
						serving_level_q <= sel_res.level;
						// expiry left no cell at all
						if (!sel_res.found && (op_q == OP_TICK_BEGIN)) begin
							mode_q <= MODE_LOST;
						end
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign total_ext = {4'b0000, total_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			link_state_q        <= mode_q;
			serving_present_q   <= serving_has_q;
			serving_id_out_q    <= serving_has_q ? serving_id_q : 16'd0;
			serving_level_out_q <= serving_has_q ? serving_level_q : 8'sd0;
			valid_cells_q       <= (total_ext > (CW + 4)'(VALID_CELLS_MAX)) ?
				VALID_CELLS_MAX : total_ext[3:0];
			beacon_due_q        <= due_q;
			ack_taken_q         <= taken_q;
		end
	end

	assign out_valid       = out_valid_q;
	assign link_state      = link_state_q;
	assign serving_present = serving_present_q;
	assign serving_id      = serving_id_out_q;
	assign serving_level   = serving_level_out_q;
	assign valid_cells     = valid_cells_q;
	assign beacon_due      = beacon_due_q;
	assign ack_taken       = ack_taken_q;

endmodule
